[design/bafm_pkg.sv]
// Shared constants, codes and types of the advertising data filter block.
package bafm_pkg;

   localparam int NUM_FILTERS    = 4;
   localparam int MAX_FILTER_LEN = 29;

   localparam int OP_W    = 2;
   localparam int FI_W    = 2;
   localparam int BI_W    = 5;
   localparam int LEN_W   = 5;
   localparam int BYTE_W  = 8;
   localparam int FIU_W   = 3;
   localparam int CSR_IDX_W = 2;

   localparam int ID_W   = $clog2(NUM_FILTERS + 1);
   localparam int CNT_W  = (ID_W > FIU_W) ? ID_W : FIU_W;
   localparam int IDX_W  = (MAX_FILTER_LEN > 1) ? $clog2(MAX_FILTER_LEN) : 1;
   localparam int POS_W  = $clog2(MAX_FILTER_LEN + 1);

   localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
   localparam logic [OP_W-1:0] OP_DATA = 2'd1;
   localparam logic [OP_W-1:0] OP_END  = 2'd2;

   localparam logic [1:0] PH_LENGTH  = 2'd0;
   localparam logic [1:0] PH_TYPE    = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;
   localparam logic [1:0] PH_STOPPED = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_FILTERS_IN_USE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RSSI_FLOOR     = 2'd1;

   localparam logic signed [BYTE_W-1:0] RSSI_NONE = 8'sd127;

   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic              load;
      cnt_type           load_fi;
      logic [BI_W-1:0]   load_bi;
      logic [BYTE_W-1:0] load_type;
      logic [LEN_W-1:0]  load_len;
      logic [BYTE_W-1:0] pattern;
      logic [BYTE_W-1:0] mask;
      logic              type_ev;
      logic              pay_ev;
      logic              finish;
      logic              clear;
      logic [BYTE_W-1:0] data;
      logic [BYTE_W-1:0] slen_m1;
      logic [POS_W-1:0]  pos;
      cnt_type           active;
   } bafm_ctl_type;

   typedef struct packed {
      logic valid;
      logic matched;
      logic rssi_pass;
   } bafm_res_type;

endpackage

[design/bafm_cell.sv]
// One filter lane: stored filter, running candidate flag, match and index chaining.
module bafm_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  bafm_pkg::bafm_ctl_type ctl,
   input  bafm_pkg::cnt_type     id_in,
   input  logic                  hit_in,
   output bafm_pkg::cnt_type     id_out,
   output logic                  hit_out
);
   import bafm_pkg::*;

   logic [BYTE_W-1:0] type_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [BYTE_W-1:0] pat_ff  [MAX_FILTER_LEN];
   logic [BYTE_W-1:0] mask_ff [MAX_FILTER_LEN];
   logic              cand_ff, cand_in, cand_next;
   logic              load_hit, pos_ok, mismatch;
   logic [BYTE_W-1:0] pat_rd, mask_rd;

   assign load_hit = ctl.load && (ctl.load_fi == id_in);
   assign pos_ok   = ({{(BYTE_W-POS_W){1'b0}}, ctl.pos} < {{(BYTE_W-LEN_W){1'b0}}, len_ff})
                     && (ctl.pos < POS_W'(MAX_FILTER_LEN));
   assign pat_rd   = pos_ok ? pat_ff[ctl.pos[IDX_W-1:0]]  : '0;
   assign mask_rd  = pos_ok ? mask_ff[ctl.pos[IDX_W-1:0]] : '0;
   assign mismatch = (ctl.data & mask_rd) != (pat_rd & mask_rd);

   always_comb begin
      cand_next = cand_ff;
      if (ctl.type_ev) begin
         cand_next = (id_in < ctl.active) && (type_ff == ctl.data)
                     && (ctl.slen_m1 >= {{(BYTE_W-LEN_W){1'b0}}, len_ff});
      end else if (ctl.pay_ev) begin
         cand_next = cand_ff && !(pos_ok && mismatch);
      end
      cand_in = (ctl.finish || ctl.clear) ? 1'b0 : cand_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff <= 1'b0;
      end else begin
         cand_ff <= cand_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_hit) begin
         type_ff <= ctl.load_type;
         len_ff  <= ctl.load_len;
         if (ctl.load_bi < BI_W'(MAX_FILTER_LEN)) begin
            pat_ff[ctl.load_bi[IDX_W-1:0]]  <= ctl.pattern;
            mask_ff[ctl.load_bi[IDX_W-1:0]] <= ctl.mask;
         end
      end
   end

   assign hit_out = hit_in | (ctl.finish & cand_next);
   assign id_out  = id_in + 1'b1;

endmodule

[design/bafm_parser.sv]
// Structure parser: length, type and payload tracking, broadcast to the lanes, report result.
module bafm_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic [bafm_pkg::OP_W-1:0]     op,
   input  logic [bafm_pkg::FI_W-1:0]     filter_index,
   input  logic [bafm_pkg::BI_W-1:0]     byte_index,
   input  logic [bafm_pkg::BYTE_W-1:0]   filter_type,
   input  logic [bafm_pkg::LEN_W-1:0]    filter_len,
   input  logic [bafm_pkg::BYTE_W-1:0]   pattern_byte,
   input  logic [bafm_pkg::BYTE_W-1:0]   mask_byte,
   input  logic [bafm_pkg::BYTE_W-1:0]   ad_byte,
   input  logic signed [bafm_pkg::BYTE_W-1:0] rssi,
   input  logic [bafm_pkg::FIU_W-1:0]    filters_in_use,
   input  logic signed [bafm_pkg::BYTE_W-1:0] rssi_floor,
   input  logic                          hit,
   output bafm_pkg::bafm_ctl_type        ctl,
   output bafm_pkg::bafm_res_type        res
);
   import bafm_pkg::*;

   logic [1:0]        phase_ff, phase_in;
   logic [BYTE_W-1:0] slen_ff, slen_in;
   logic [BYTE_W-1:0] left_ff, left_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              found_ff, found_in;
   logic              data_ev;
   cnt_type           fiu_ext;

   assign data_ev = fire && (op == OP_DATA);
   assign fiu_ext = CNT_W'(filters_in_use);

   always_comb begin
      ctl           = '0;
      ctl.load      = fire && (op == OP_LOAD);
      ctl.load_fi   = CNT_W'(filter_index);
      ctl.load_bi   = byte_index;
      ctl.load_type = filter_type;
      ctl.load_len  = (filter_len > LEN_W'(MAX_FILTER_LEN)) ? LEN_W'(MAX_FILTER_LEN) : filter_len;
      ctl.pattern   = pattern_byte;
      ctl.mask      = mask_byte;
      ctl.data      = ad_byte;
      ctl.slen_m1   = slen_ff - 1'b1;
      ctl.pos       = pos_ff;
      ctl.active    = (fiu_ext > CNT_W'(NUM_FILTERS)) ? CNT_W'(NUM_FILTERS) : fiu_ext;
      ctl.clear     = fire && (op == OP_END);
      ctl.type_ev   = data_ev && (phase_ff == PH_TYPE);
      ctl.pay_ev    = data_ev && (phase_ff == PH_PAYLOAD);
      ctl.finish    = (ctl.type_ev && (slen_ff == 8'd1))
                      || (ctl.pay_ev && (left_ff == 8'd1));

      phase_in = phase_ff;
      slen_in  = slen_ff;
      left_in  = left_ff;
      pos_in   = pos_ff;
      found_in = found_ff | hit;
      if (ctl.clear) begin
         phase_in = PH_LENGTH;
         slen_in  = '0;
         left_in  = '0;
         pos_in   = '0;
         found_in = 1'b0;
      end else if (data_ev) begin
         case (phase_ff)
            PH_LENGTH: begin
               if (ad_byte == '0) begin
                  phase_in = PH_STOPPED;
               end else begin
                  slen_in  = ad_byte;
                  phase_in = PH_TYPE;
               end
            end
            PH_TYPE: begin
               left_in  = slen_ff - 1'b1;
               pos_in   = '0;
               phase_in = ctl.finish ? PH_LENGTH : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               left_in  = left_ff - 1'b1;
               pos_in   = (pos_ff == POS_W'(MAX_FILTER_LEN)) ? pos_ff : pos_ff + 1'b1;
               phase_in = ctl.finish ? PH_LENGTH : PH_PAYLOAD;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LENGTH;
         slen_ff  <= '0;
         left_ff  <= '0;
         pos_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         slen_ff  <= slen_in;
         left_ff  <= left_in;
         pos_ff   <= pos_in;
         found_ff <= found_in;
      end
   end

   assign res.valid     = ctl.clear;
   assign res.matched   = found_ff;
   assign res.rssi_pass = (rssi_floor == RSSI_NONE)
                          || ((rssi != RSSI_NONE) && (rssi >= rssi_floor));

endmodule

[design/bafm_out_skid.sv]
// Result output register with one skid entry.
module bafm_out_skid (
   input  logic                   clock,
   input  logic                   reset,
   input  bafm_pkg::bafm_res_type res,
   output logic                   space,
   output logic                   skid_full,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_matched,
   output logic                   rsp_rssi_pass
);
   import bafm_pkg::*;

   logic out_valid_ff, out_valid_in;
   logic skid_valid_ff, skid_valid_in;
   logic [1:0] out_ff, out_in, skid_ff, skid_in;
   logic out_free;

   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = res.valid;
            skid_in       = {res.matched, res.rssi_pass};
         end else begin
            out_valid_in  = res.valid;
            out_in        = {res.matched, res.rssi_pass};
         end
      end else if (res.valid) begin
         skid_valid_in = 1'b1;
         skid_in       = {res.matched, res.rssi_pass};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign space         = !skid_valid_ff;
   assign skid_full     = skid_valid_ff;
   assign rsp_valid     = out_valid_ff;
   assign rsp_matched   = out_ff[1];
   assign rsp_rssi_pass = out_ff[0];

endmodule

[design/ble_ad_filter_match_core.sv]
// Top level of the advertising data filter: registers, parser, lane row and result stage.
// Every transaction (filter load, data byte or end of report) is accepted whenever req_ready
// is high, and a new one may be accepted in every cycle while the skid is empty: each data byte
// updates the whole row of filter lanes in the cycle it is accepted, and the end of report
// result is registered into the rsp_ output register, or into the skid while that register
// holds a result not yet taken. req_ready drops only while the skid holds a result. Filter
// stores are not cleared by reset, and configuration writes are always accepted.
module ble_ad_filter_match_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bafm_pkg::OP_W-1:0]     req_op,
   input  logic [bafm_pkg::FI_W-1:0]     req_filter_index,
   input  logic [bafm_pkg::BI_W-1:0]     req_byte_index,
   input  logic [bafm_pkg::BYTE_W-1:0]   req_filter_type,
   input  logic [bafm_pkg::LEN_W-1:0]    req_filter_len,
   input  logic [bafm_pkg::BYTE_W-1:0]   req_pattern_byte,
   input  logic [bafm_pkg::BYTE_W-1:0]   req_mask_byte,
   input  logic [bafm_pkg::BYTE_W-1:0]   req_ad_byte,
   input  logic signed [bafm_pkg::BYTE_W-1:0] req_rssi,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_matched,
   output logic                          rsp_rssi_pass,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bafm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bafm_pkg::BYTE_W-1:0]   csr_wdata
);
   import bafm_pkg::*;

   logic [FIU_W-1:0]         fiu_ff;
   logic signed [BYTE_W-1:0] thr_ff;
   logic                     req_fire, space, skid_full;
   bafm_ctl_type             ctl;
   bafm_res_type             res;
   cnt_type                  id_chain [NUM_FILTERS+1];
   logic                     hit_chain [NUM_FILTERS+1];

   assign csr_ready = 1'b1;
   assign req_ready = space;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fiu_ff <= '0;
         thr_ff <= RSSI_NONE;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_FILTERS_IN_USE) begin
            fiu_ff <= csr_wdata[FIU_W-1:0];
         end else if (csr_index == CSR_RSSI_FLOOR) begin
            thr_ff <= csr_wdata;
         end
      end
   end

   bafm_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .fire           (req_fire),
      .op             (req_op),
      .filter_index   (req_filter_index),
      .byte_index     (req_byte_index),
      .filter_type    (req_filter_type),
      .filter_len     (req_filter_len),
      .pattern_byte   (req_pattern_byte),
      .mask_byte      (req_mask_byte),
      .ad_byte        (req_ad_byte),
      .rssi           (req_rssi),
      .filters_in_use (fiu_ff),
      .rssi_floor     (thr_ff),
      .hit            (hit_chain[NUM_FILTERS]),
      .ctl            (ctl),
      .res            (res)
   );

   assign id_chain[0]  = '0;
   assign hit_chain[0] = 1'b0;

   for (genvar g = 0; g < NUM_FILTERS; g++) begin : g_lane
      bafm_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .id_in   (id_chain[g]),
         .hit_in  (hit_chain[g]),
         .id_out  (id_chain[g+1]),
         .hit_out (hit_chain[g+1])
      );
   end

   bafm_out_skid u_out (
      .clock         (clock),
      .reset         (reset),
      .res           (res),
      .space         (space),
      .skid_full     (skid_full),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_matched   (rsp_matched),
      .rsp_rssi_pass (rsp_rssi_pass)
   );

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_full |-> rsp_valid)
      else $error("skid holds a result while the output register is empty");

   a_rsp_from_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && (req_op == OP_END)))
      else $error("result raised without an end of report transaction");

   a_hit_on_finish: assert property (@(posedge clock) disable iff (reset)
      hit_chain[NUM_FILTERS] |-> ctl.finish)
      else $error("lane match outside a structure end");

endmodule

[sim/ble_ad_filter_match_core_tb.sv]
// Self-checking testbench for the advertising data filter core: directed table, then random reports.
`timescale 1ns / 100ps

module ble_ad_filter_match_core_tb;
   import bafm_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 1450;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 4;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic [FI_W-1:0]          fi;
      logic [BI_W-1:0]          bi;
      logic [BYTE_W-1:0]        ftype;
      logic [LEN_W-1:0]         flen;
      logic [BYTE_W-1:0]        pat;
      logic [BYTE_W-1:0]        msk;
      logic [BYTE_W-1:0]        ad;
      logic signed [BYTE_W-1:0] rssi;
   } ad_req_type;

   typedef struct {
      bit                     is_csr;
      logic [CSR_IDX_W-1:0]   reg_idx;
      logic [BYTE_W-1:0]      reg_val;
      ad_req_type             req;
      bit                     typed;
      logic [1:0]             want;
   } dir_row_type;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   wire                           req_ready;
   logic [OP_W-1:0]               req_op = '0;
   logic [FI_W-1:0]               req_filter_index = '0;
   logic [BI_W-1:0]               req_byte_index = '0;
   logic [BYTE_W-1:0]             req_filter_type = '0;
   logic [LEN_W-1:0]              req_filter_len = '0;
   logic [BYTE_W-1:0]             req_pattern_byte = '0;
   logic [BYTE_W-1:0]             req_mask_byte = '0;
   logic [BYTE_W-1:0]             req_ad_byte = '0;
   logic signed [BYTE_W-1:0]      req_rssi = '0;
   wire                           rsp_valid;
   logic                          rsp_ready = 1'b0;
   wire                           rsp_matched;
   wire                           rsp_rssi_pass;
   logic                          csr_valid = 1'b0;
   wire                           csr_ready;
   logic [CSR_IDX_W-1:0]          csr_index = '0;
   logic [BYTE_W-1:0]             csr_wdata = '0;

   // filter shadow and parser state of the predictor
   logic [BYTE_W-1:0]        pr_type [NUM_FILTERS];
   logic [LEN_W-1:0]         pr_len [NUM_FILTERS];
   logic [BYTE_W-1:0]        pr_pat [NUM_FILTERS][MAX_FILTER_LEN];
   logic [BYTE_W-1:0]        pr_mask [NUM_FILTERS][MAX_FILTER_LEN];
   logic [1:0]               pr_phase;
   logic [BYTE_W-1:0]        pr_slen;
   logic [BYTE_W-1:0]        pr_left;
   logic [BYTE_W-1:0]        pr_pos;
   logic                     pr_cand [NUM_FILTERS];
   logic                     pr_hit;
   logic [FIU_W-1:0]         pr_fiu;
   logic signed [BYTE_W-1:0] pr_thr;

   logic [1:0]   verdict_q [$];   // {matched, rssi_pass} per end of report
   dir_row_type  dir_rows [$];
   logic [1:0]   oldest;
   int           err_cnt = 0;
   int           cycle_cnt = 0;
   int           n_items = 0;
   int           burst_left = 0;
   int           stall_win = 0;
   int           stall_mode = 0;

   ble_ad_filter_match_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_filter_index (req_filter_index),
      .req_byte_index   (req_byte_index),
      .req_filter_type  (req_filter_type),
      .req_filter_len   (req_filter_len),
      .req_pattern_byte (req_pattern_byte),
      .req_mask_byte    (req_mask_byte),
      .req_ad_byte      (req_ad_byte),
      .req_rssi         (req_rssi),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_matched      (rsp_matched),
      .rsp_rssi_pass    (rsp_rssi_pass),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [BYTE_W-1:0] rnd8();
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [BYTE_W-1:0] pick_mask();
      case ($urandom_range(0, 3))
         0: return 8'hFF;
         1: return 8'h00;
         default: return rnd8();
      endcase
   endfunction

   // mostly short filters so that matches stay frequent
   function automatic logic [LEN_W-1:0] pick_len();
      if ($urandom_range(0, 4) == 0)
         return LEN_W'($urandom_range(0, 31));
      return LEN_W'($urandom_range(0, 5));
   endfunction

   // unused fields carry junk
   function automatic ad_req_type scrap();
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      return junk[$bits(ad_req_type)-1:0];
   endfunction

   function automatic ad_req_type load_item(logic [FI_W-1:0] fi, logic [BI_W-1:0] bi,
                                            logic [BYTE_W-1:0] ty, logic [LEN_W-1:0] len,
                                            logic [BYTE_W-1:0] pat, logic [BYTE_W-1:0] msk);
      ad_req_type r;
      r = scrap();
      r.op = OP_LOAD;
      r.fi = fi;
      r.bi = bi;
      r.ftype = ty;
      r.flen = len;
      r.pat = pat;
      r.msk = msk;
      return r;
   endfunction

   function automatic ad_req_type data_item(logic [BYTE_W-1:0] b);
      ad_req_type r;
      r = scrap();
      r.op = OP_DATA;
      r.ad = b;
      return r;
   endfunction

   function automatic ad_req_type end_item(logic signed [BYTE_W-1:0] rs);
      ad_req_type r;
      r = scrap();
      r.op = OP_END;
      r.rssi = rs;
      return r;
   endfunction

   function automatic ad_req_type noise_item();
      ad_req_type r;
      r = scrap();
      r.op = OP_UNUSED;
      return r;
   endfunction

   function automatic void row(ad_req_type r, bit typed = 1'b0, logic [1:0] want = 2'b00);
      dir_row_type d;
      d.is_csr = 1'b0;
      d.reg_idx = '0;
      d.reg_val = '0;
      d.req = r;
      d.typed = typed;
      d.want = want;
      dir_rows.push_back(d);
   endfunction

   function automatic void row_reg(logic [CSR_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
      dir_row_type d;
      d.is_csr = 1'b1;
      d.reg_idx = idx;
      d.reg_val = val;
      d.req = '0;
      d.typed = 1'b0;
      d.want = 2'b00;
      dir_rows.push_back(d);
   endfunction

   task automatic clear_parse();
      pr_phase = PH_LENGTH;
      pr_slen = '0;
      pr_left = '0;
      pr_pos = '0;
      pr_hit = 1'b0;
      for (int f = 0; f < NUM_FILTERS; f++) pr_cand[f] = 1'b0;
   endtask

   task automatic close_struct();
      for (int f = 0; f < NUM_FILTERS; f++) begin
         if (pr_cand[f]) pr_hit = 1'b1;
         pr_cand[f] = 1'b0;
      end
      pr_phase = PH_LENGTH;
   endtask

   task automatic parse_ad_byte(input logic [BYTE_W-1:0] b);
      int active;
      case (pr_phase)
         PH_LENGTH: begin
            if (b == 8'd0) begin
               pr_phase = PH_STOPPED;
            end else begin
               pr_slen = b;
               pr_phase = PH_TYPE;
            end
         end
         PH_TYPE: begin
            active = (int'(pr_fiu) > NUM_FILTERS) ? NUM_FILTERS : int'(pr_fiu);
            for (int f = 0; f < NUM_FILTERS; f++)
               pr_cand[f] = (f < active) && (pr_type[f] == b) &&
                            (int'(pr_slen) - 1 >= int'(pr_len[f]));
            pr_left = pr_slen - 8'd1;
            pr_pos = '0;
            if (pr_left == 8'd0) close_struct();
            else pr_phase = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            for (int f = 0; f < NUM_FILTERS; f++) begin
               if (pr_cand[f] && int'(pr_pos) < int'(pr_len[f]) &&
                   int'(pr_pos) < MAX_FILTER_LEN) begin
                  if ((b & pr_mask[f][pr_pos]) != (pr_pat[f][pr_pos] & pr_mask[f][pr_pos]))
                     pr_cand[f] = 1'b0;
               end
            end
            if (pr_pos != 8'd255) pr_pos = pr_pos + 8'd1;
            pr_left = pr_left - 8'd1;
            if (pr_left == 8'd0) close_struct();
         end
         default: ;
      endcase
   endtask

   task automatic predict_report(input ad_req_type r, output bit produced,
                                 output logic [1:0] res);
      produced = 1'b0;
      res = 2'b00;
      case (r.op)
         OP_LOAD: begin
            pr_type[r.fi] = r.ftype;
            pr_len[r.fi] = (int'(r.flen) > MAX_FILTER_LEN) ? LEN_W'(MAX_FILTER_LEN) : r.flen;
            if (int'(r.bi) < MAX_FILTER_LEN) begin
               pr_pat[r.fi][r.bi] = r.pat;
               pr_mask[r.fi][r.bi] = r.msk;
            end
         end
         OP_DATA: parse_ad_byte(r.ad);
         OP_END: begin
            produced = 1'b1;
            res[1] = pr_hit;
            res[0] = (pr_thr == RSSI_NONE) ||
                     ($signed(r.rssi) != RSSI_NONE && $signed(r.rssi) >= pr_thr);
            clear_parse();
         end
         default: ;
      endcase
   endtask

   // one transaction on the request channel, with bursty spacing
   task automatic issue(input ad_req_type r, input bit typed = 1'b0,
                        input logic [1:0] want = 2'b00);
      int gap;
      bit produced;
      logic [1:0] res;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_op <= r.op;
      req_filter_index <= r.fi;
      req_byte_index <= r.bi;
      req_filter_type <= r.ftype;
      req_filter_len <= r.flen;
      req_pattern_byte <= r.pat;
      req_mask_byte <= r.msk;
      req_ad_byte <= r.ad;
      req_rssi <= r.rssi;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_report(r, produced, res);
      if (produced) verdict_q.push_back(typed ? want : res);
      if (r.op != OP_UNUSED) n_items++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_FILTERS_IN_USE) pr_fiu = val[FIU_W-1:0];
      else if (idx == CSR_RSSI_FLOOR) pr_thr = val;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic stray_load();
      logic [FI_W-1:0] fi;
      fi = FI_W'($urandom_range(0, NUM_FILTERS - 1));
      issue(load_item(fi, BI_W'($urandom_range(0, 31)),
                      ($urandom_range(0, 3) == 0) ? rnd8() : pr_type[fi],
                      ($urandom_range(0, 2) == 0) ? pick_len() : pr_len[fi],
                      rnd8(), pick_mask()));
   endtask

   // a report of well-formed structures aimed at the loaded filters, then an odd tail
   task automatic send_report();
      int n_struct, f, plen, k, i, s;
      logic [BYTE_W-1:0] typ;
      logic [BYTE_W-1:0] b;
      logic signed [BYTE_W-1:0] rs;
      n_struct = $urandom_range(0, 4);
      for (s = 0; s < n_struct; s++) begin
         f = $urandom_range(0, NUM_FILTERS - 1);
         case ($urandom_range(0, 9))
            0: begin
               typ = rnd8();
               plen = $urandom_range(0, 34);
            end
            1: begin
               typ = pr_type[f];
               plen = (pr_len[f] == '0) ? 0 : int'(pr_len[f]) - 1;
            end
            default: begin
               typ = pr_type[f];
               plen = int'(pr_len[f]) + $urandom_range(0, 3);
            end
         endcase
         issue(data_item(BYTE_W'(plen + 1)));
         issue(data_item(typ));
         for (k = 0; k < plen; k++) begin
            if (k < MAX_FILTER_LEN && $urandom_range(0, 19) != 0)
               b = pr_pat[f][k] ^ (rnd8() & ~pr_mask[f][k]);
            else
               b = rnd8();
            issue(data_item(b));
            if ($urandom_range(0, 39) == 0) stray_load();
            if ($urandom_range(0, 49) == 0) issue(noise_item());
         end
      end
      case ($urandom_range(0, 9))
         0: begin
            plen = $urandom_range(2, 20);
            f = $urandom_range(0, NUM_FILTERS - 1);
            issue(data_item(BYTE_W'(plen)));
            k = $urandom_range(0, plen - 1);
            for (i = 0; i < k; i++) issue(data_item((i == 0) ? pr_type[f] : rnd8()));
         end
         1: begin
            issue(data_item(8'd0));
            k = $urandom_range(0, 6);
            for (i = 0; i < k; i++) issue(data_item(rnd8()));
         end
         default: ;
      endcase
      case ($urandom_range(0, 5))
         0: rs = RSSI_NONE;
         1: rs = 8'sh80;
         2: rs = pr_thr;
         3: rs = (pr_thr == 8'sh80) ? pr_thr : pr_thr - 8'sd1;
         default: rs = rnd8();
      endcase
      issue(end_item(rs));
   endtask

   function automatic void build_directed();
      row(end_item(8'sh80), 1'b1, 2'b01);
      row(data_item(8'd1));
      row(data_item(8'h00));
      row(end_item(RSSI_NONE), 1'b1, 2'b01);
      row(load_item(2'd0, 5'd0, 8'hFF, 5'd2, 8'h00, 8'hFF));
      row(load_item(2'd0, 5'd1, 8'hFF, 5'd2, 8'hA0, 8'hF0));
      row(load_item(2'd0, 5'd31, 8'hFF, 5'd2, 8'hFF, 8'hFF));
      row(load_item(2'd3, 5'd29, 8'h00, 5'd31, 8'h5A, 8'h00));
      row_reg(CSR_FILTERS_IN_USE, 8'd1);
      row_reg(CSR_RSSI_FLOOR, 8'h80);
      row(data_item(8'd4));
      row(data_item(8'hFF));
      row(data_item(8'h00));
      row(data_item(8'hAF));
      row(data_item(8'h55));
      row(noise_item());
      row(end_item(8'sh80));
      // structure cut off by the end of report, rssi unknown
      row(data_item(8'd5));
      row(data_item(8'hFF));
      row(data_item(8'h00));
      row(end_item(RSSI_NONE), 1'b1, 2'b00);
      // zero length stops parsing
      row(data_item(8'd0));
      row(data_item(8'd3));
      row(data_item(8'hFF));
      row(data_item(8'h00));
      row(data_item(8'hA0));
      row(end_item(8'sd0), 1'b1, 2'b01);
   endfunction

   always @(posedge clock) begin
      if (stall_win == 0) begin
         stall_win = $urandom_range(8, 120);
         stall_mode = $urandom_range(0, 2);
      end
      stall_win--;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 1);
         default: rsp_ready <= ((stall_win % 7) >= 3);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdict_q.size() == 0) begin
            err_cnt++;
            $display("%0t: result with none expected: matched %0b rssi_pass %0b",
                     $time, rsp_matched, rsp_rssi_pass);
         end else begin
            oldest = verdict_q.pop_front();
            if (rsp_matched !== oldest[1]) begin
               err_cnt++;
               $display("%0t: matched expected %0b actual %0b", $time, oldest[1], rsp_matched);
            end
            if (rsp_rssi_pass !== oldest[0]) begin
               err_cnt++;
               $display("%0t: rssi_pass expected %0b actual %0b",
                        $time, oldest[0], rsp_rssi_pass);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int p, reps, i, f, bi;
      logic [BYTE_W-1:0] ty;
      logic [LEN_W-1:0] ln;
      logic [BYTE_W-1:0] thr;
      clear_parse();
      pr_fiu = '0;
      pr_thr = RSSI_NONE;
      build_directed();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < dir_rows.size(); i++) begin
         if (dir_rows[i].is_csr) begin
            settle();
            write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
         end else begin
            issue(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
         end
      end

      // every pattern and mask byte is written before the random reports read them
      for (f = 0; f < NUM_FILTERS; f++) begin
         ty = rnd8();
         ln = pick_len();
         for (bi = 0; bi < MAX_FILTER_LEN; bi++)
            issue(load_item(FI_W'(f), BI_W'(bi), ty, ln, rnd8(), pick_mask()));
      end

      p = 0;
      while (n_items < ITEM_TARGET) begin
         settle();
         if (p < 8) write_reg(CSR_FILTERS_IN_USE, BYTE_W'(p));
         else write_reg(CSR_FILTERS_IN_USE,
                        ($urandom_range(0, 1) == 0) ? 8'd4 : BYTE_W'($urandom_range(0, 7)));
         case (p % 5)
            0: thr = 8'h7F;
            1: thr = 8'h80;
            2: thr = 8'h00;
            default: thr = rnd8();
         endcase
         write_reg(CSR_RSSI_FLOOR, thr);
         reps = $urandom_range(3, 10);
         for (i = 0; i < reps; i++) begin
            if ($urandom_range(0, 3) == 0) stray_load();
            send_report();
         end
         p++;
      end

      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (err_cnt == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
